>>> src/text_line_number_escape_filter_unit_assert.svh
// Assertion macros shared by the filter's RTL files.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef TEXT_LINE_NUMBER_ESCAPE_FILTER_UNIT_ASSERT_SVH
`define TEXT_LINE_NUMBER_ESCAPE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TLNEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLNEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tlnef_pkg.sv
// Types, character codes and the escape function of the text filter.
// No dependencies; used by the front end, queue, back end, top level and testbench.
`default_nettype none

package tlnef_pkg;

  localparam int CFG_IW = 3;
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef enum logic [CFG_IW-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_DOLLAR_EOL       = 3'd3,
    CFG_CARET_TAB        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_HI_SP  = 8'hA0;
  localparam logic [7:0] CH_HI_DEL = 8'hFF;
  localparam logic [7:0] CARET_OFS = 8'h40;
  localparam logic [7:0] HIGH_OFS  = 8'h80;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic dollar_eol;
    logic caret_tab;
    logic show_nonprinting;
  } cfg_t;

  // character bytes of one job, chr[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] chr;
    logic [2:0]      n_chr;
  } esc_t;

  typedef struct packed {
    logic has_num;
    esc_t body;
  } job_t;

  function automatic esc_t escape_char(input logic [7:0] c, input logic sn, input logic st);
    esc_t r;
    r.chr   = '0;
    r.n_chr = 3'd1;
    r.chr[0] = c;
    if (sn) begin
      if (c >= CH_SPACE) begin
        if (c < CH_DEL) begin
          r.chr[0] = c;
        end else if (c == CH_DEL) begin
          r.chr[0] = CH_CARET;
          r.chr[1] = CH_QMARK;
          r.n_chr  = 3'd2;
        end else begin
          r.chr[0] = CH_M;
          r.chr[1] = CH_DASH;
          if (c >= CH_HI_SP) begin
            if (c < CH_HI_DEL) begin
              r.chr[2] = c - HIGH_OFS;
              r.n_chr  = 3'd3;
            end else begin
              r.chr[2] = CH_CARET;
              r.chr[3] = CH_QMARK;
              r.n_chr  = 3'd4;
            end
          end else begin
            r.chr[2] = CH_CARET;
            r.chr[3] = c - CARET_OFS;
            r.n_chr  = 3'd4;
          end
        end
      end else if (c == CH_TAB && !st) begin
        r.chr[0] = c;
      end else begin
        r.chr[0] = CH_CARET;
        r.chr[1] = c + CARET_OFS;
        r.n_chr  = 3'd2;
      end
    end else if (st && c == CH_TAB) begin
      r.chr[0] = CH_CARET;
      r.chr[1] = c + CARET_OFS;
      r.n_chr  = 3'd2;
    end
    return r;
  endfunction

  function automatic esc_t newline_chars(input logic se);
    esc_t r;
    r.chr = '0;
    if (se) begin
      r.chr[0] = CH_DOLLAR;
      r.chr[1] = CH_LF;
      r.n_chr  = 3'd2;
    end else begin
      r.chr[0] = CH_LF;
      r.n_chr  = 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tlnef_if.sv
// Valid/ready channel interfaces of the text filter: input bytes and output bytes.
// No dependencies.
`default_nettype none

interface tlnef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_file;
  modport source (output valid, output data_byte, output new_file, input ready);
  modport sink (input valid, input data_byte, input new_file, output ready);
endinterface

interface tlnef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

>>> src/tlnef_front.sv
// Front end: accepts input words, tracks line state and the BCD line count,
// and pushes one job per producing word into the queue. Uses tlnef_pkg, tlnef_if.
`default_nettype none
`include "text_line_number_escape_filter_unit_assert.svh"

module tlnef_front import tlnef_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tlnef_in_if.sink                          in_if,
  input  wire cfg_t                         cfg,
  input  wire logic                         q_full,
  output logic                              push,
  output job_t                              job,
  output logic [4*NUMBER_DIGITS-1:0]        job_num
);

  localparam int NB = 4 * NUMBER_DIGITS;

  logic          als_r, als_nxt;
  logic          skip_r, skip_nxt;
  logic [NB-1:0] cnt_r, cnt_nxt;
  logic          accept;
  logic          als, skip, is_lf, emit_nl;

  function automatic logic [NB-1:0] bcd_inc(input logic [NB-1:0] v);
    logic [NB-1:0] r;
    logic          carry;
    logic          all9;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return all9 ? v : r;
  endfunction

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign job_num     = cnt_r;

  always_comb begin
    // a new file restarts the line before this byte is looked at
    als      = in_if.new_file || als_r;
    skip     = !in_if.new_file && skip_r;
    is_lf    = in_if.data_byte == CH_LF;
    emit_nl  = !(cfg.squeeze_blank && skip);
    als_nxt  = als;
    skip_nxt = skip;
    job.has_num = 1'b0;
    job.body    = escape_char(in_if.data_byte, cfg.show_nonprinting, cfg.caret_tab);
    if (als) begin
      if (is_lf) begin
        job.has_num = emit_nl && cfg.number_all && !cfg.number_nonblank;
        job.body    = newline_chars(cfg.dollar_eol);
        if (!emit_nl) job.body.n_chr = 3'd0;
        if (cfg.squeeze_blank) skip_nxt = 1'b1;
      end else begin
        job.has_num = cfg.number_all || cfg.number_nonblank;
        skip_nxt    = 1'b0;
        als_nxt     = 1'b0;
      end
    end else if (is_lf) begin
      job.body = newline_chars(cfg.dollar_eol);
      als_nxt  = 1'b1;
    end
    cnt_nxt = job.has_num ? bcd_inc(cnt_r) : cnt_r;
    push    = accept && (job.has_num || job.body.n_chr != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      als_r  <= 1'b1;
      skip_r <= 1'b0;
      cnt_r  <= NB'(1);
    end else if (accept) begin
      als_r  <= als_nxt;
      skip_r <= skip_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `TLNEF_ASSERT_NXT(a_cnt_hold, accept && !job.has_num, $stable(cnt_r), "count moved without a number")
  `TLNEF_ASSERT_IMP(a_no_push_full, q_full, !push, "push into a full queue")

endmodule

`default_nettype wire

>>> src/tlnef_queue.sv
// Short job queue between front and back end, register based, first in first out.
// Uses tlnef_pkg for its depth.
`default_nettype none
`include "text_line_number_escape_filter_unit_assert.svh"

module tlnef_queue import tlnef_pkg::*; #(
  parameter int W = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              q_valid,
  output logic              q_full
);

  localparam int CW = $clog2(QDEPTH + 1);

  logic [W-1:0]   slot_r [QDEPTH];
  logic [QPW-1:0] wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign rdata   = slot_r[rptr_r];
  assign q_valid = cnt_r != '0;
  assign q_full  = cnt_r == CW'(QDEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPW'(1);
      if (pop)  rptr_r <= rptr_r + QPW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `TLNEF_ASSERT_IMP(a_pop_empty, pop, q_valid, "pop from an empty queue")
  `TLNEF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CW'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

>>> src/tlnef_back.sv
// Back end: walks the head job byte by byte (number digits, tab, characters)
// into a registered output word. Uses tlnef_pkg, tlnef_if.
`default_nettype none
`include "text_line_number_escape_filter_unit_assert.svh"

module tlnef_back import tlnef_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire job_t                      job,
  input  wire logic [4*NUMBER_DIGITS-1:0] job_num,
  input  wire logic                      q_valid,
  output logic                           pop,
  tlnef_out_if.source                    out_if
);

  localparam int PW = $clog2(NUMBER_DIGITS + 5);
  localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  logic          busy_r;
  logic [PW-1:0] pos_r;
  logic          vld_r;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [PW-1:0] cur, ci_full;
  logic [DW-1:0] di;
  logic [3:0]    digit;
  logic          blank;
  logic          step;

  assign step = q_valid && (!vld_r || out_if.ready);
  assign pop  = step && last_nxt;

  always_comb begin
    // positions: digits, then tab, then character bytes
    cur      = busy_r ? pos_r : (job.has_num ? '0 : PW'(NUMBER_DIGITS + 1));
    di       = DW'(NUMBER_DIGITS - 1) - cur[DW-1:0];
    digit    = job_num[4*di +: 4];
    blank    = (di != '0) && ((job_num >> {di, 2'b00}) == '0);
    ci_full  = cur - PW'(NUMBER_DIGITS + 1);
    last_nxt = cur == (PW'(NUMBER_DIGITS) + PW'(job.body.n_chr));
    if (cur < PW'(NUMBER_DIGITS)) begin
      byte_nxt = blank ? CH_SPACE : CH_ZERO + {4'd0, digit};
    end else if (cur == PW'(NUMBER_DIGITS)) begin
      byte_nxt = CH_TAB;
    end else begin
      byte_nxt = job.body.chr[ci_full[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
      vld_r  <= 1'b0;
    end else if (step) begin
      vld_r  <= 1'b1;
      busy_r <= !last_nxt;
      pos_r  <= cur + PW'(1);
    end else if (out_if.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_if.valid    = vld_r;
  assign out_if.out_byte = byte_r;
  assign out_if.last     = last_r;

  `TLNEF_ASSERT_IMP(a_busy_head, busy_r, q_valid, "job in progress lost its queue entry")

endmodule

`default_nettype wire

>>> src/text_line_number_escape_filter_unit.sv
// Top level of the line-numbering and escaping text filter: configuration
// registers, front end, job queue and back end. Uses tlnef_pkg, tlnef_if.
//
// Usage: in_if carries one text byte per word with new_file marking the
// first byte of a file; out_if carries formatted bytes, last set on the
// final byte produced for an input word. Words that produce nothing (a
// squeezed blank line) give no output word at all.
// Timing: an accepted word is written into the job queue; its first output
// byte is loaded from the queue head into the output register once that
// register is free. Throughput: while the receiver is ready, the back end
// emits one byte per cycle; a word expands to 1 to NUMBER_DIGITS+5 bytes,
// and plain bytes flow at one word per cycle. The front end takes a word
// each cycle while the four-entry job queue has room. A receiver stall holds
// the output register; the queue fills and then in ready drops. Reset clears
// the options, sets the count to one and the line state to start of line.
// Configuration is written through cfg_we, cfg_index and cfg_data (bit 0);
// the user must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module text_line_number_escape_filter_unit import tlnef_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tlnef_in_if.sink               in_if,
  tlnef_out_if.source            out_if,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic              cfg_data
);

  localparam int QW = $bits(job_t) + 4 * NUMBER_DIGITS;

  cfg_t                       cfg_r;
  logic                       push, pop, q_valid, q_full;
  job_t                       f_job, b_job;
  logic [4*NUMBER_DIGITS-1:0] f_num, b_num;
  logic [QW-1:0]              q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NUMBER_ALL:       cfg_r.number_all       <= cfg_data;
        CFG_NUMBER_NONBLANK:  cfg_r.number_nonblank  <= cfg_data;
        CFG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_data;
        CFG_DOLLAR_EOL:       cfg_r.dollar_eol       <= cfg_data;
        CFG_CARET_TAB:        cfg_r.caret_tab        <= cfg_data;
        CFG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_data;
        default: ;
      endcase
    end
  end

  tlnef_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (push),
    .job     (f_job),
    .job_num (f_num)
  );

  tlnef_queue #(.W(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   ({f_job, f_num}),
    .pop     (pop),
    .rdata   (q_rdata),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  assign b_job = q_rdata[QW-1 -: $bits(job_t)];
  assign b_num = q_rdata[4*NUMBER_DIGITS-1:0];

  tlnef_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (b_job),
    .job_num (b_num),
    .q_valid (q_valid),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

>>> tb/text_line_number_escape_filter_unit_test.sv
// Self-checking testbench of the text filter: a behavioural predictor works out
// the output bytes of each accepted word; a monitor checks them in order.
// Depends on tlnef_pkg, tlnef_if and text_line_number_escape_filter_unit.
`default_nettype none

module text_line_number_escape_filter_unit_test;
  import tlnef_pkg::*;

  localparam int NUM_DIGITS    = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic              cfg_data;

  tlnef_in_if  in_ch();
  tlnef_out_if out_ch();

  text_line_number_escape_filter_unit #(.NUMBER_DIGITS(NUM_DIGITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  cfg_t                    opts;
  logic                    at_start;
  logic                    skip_blank;
  logic [4*NUM_DIGITS-1:0] line_bcd;
  logic [7:0]              step_bytes[$];
  out_word_t               expected_bytes[$];

  int n_errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_taken;
  int hold_left;
  out_word_t head_word;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void bump_line_count();
    bit nines;
    nines = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++)
      if (line_bcd[4*i +: 4] != 4'd9) nines = 1'b0;
    if (!nines) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (line_bcd[4*i +: 4] == 4'd9) begin
          line_bcd[4*i +: 4] = 4'd0;
        end else begin
          line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
          break;
        end
      end
    end
  endfunction

  function automatic void push_line_number();
    bit         lead;
    logic [3:0] d;
    lead = 1'b1;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      d = line_bcd[4*i +: 4];
      if (d != 4'd0 || i == 0) lead = 1'b0;
      step_bytes.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
    end
    step_bytes.push_back(CH_TAB);
    bump_line_count();
  endfunction

  // caret notation of a 7-bit code; printable codes pass unchanged
  function automatic void push_seven_bit(input logic [6:0] low);
    if (low < 7'h20) begin
      step_bytes.push_back(CH_CARET);
      step_bytes.push_back({1'b0, low} + CARET_OFS);
    end else if ({1'b0, low} == CH_DEL) begin
      step_bytes.push_back(CH_CARET);
      step_bytes.push_back(CH_QMARK);
    end else begin
      step_bytes.push_back({1'b0, low});
    end
  endfunction

  function automatic void push_escaped(input logic [7:0] c);
    if (opts.show_nonprinting) begin
      if (c[7]) begin
        step_bytes.push_back(CH_M);
        step_bytes.push_back(CH_DASH);
        push_seven_bit(c[6:0]);
      end else if (c == CH_TAB && !opts.caret_tab) begin
        step_bytes.push_back(c);
      end else begin
        push_seven_bit(c[6:0]);
      end
    end else if (opts.caret_tab && c == CH_TAB) begin
      step_bytes.push_back(CH_CARET);
      step_bytes.push_back(CH_TAB + CARET_OFS);
    end else begin
      step_bytes.push_back(c);
    end
  endfunction

  function automatic void push_newline();
    if (opts.dollar_eol) step_bytes.push_back(CH_DOLLAR);
    step_bytes.push_back(CH_LF);
  endfunction

  function automatic void predict_word(input logic [7:0] c, input logic nf);
    step_bytes.delete();
    if (nf) begin
      at_start   = 1'b1;
      skip_blank = 1'b0;
    end
    if (at_start) begin
      if (c == CH_LF) begin
        // blank line: dropped while squeezing a run
        if (!(opts.squeeze_blank && skip_blank)) begin
          if (opts.number_all && !opts.number_nonblank) push_line_number();
          push_newline();
        end
        if (opts.squeeze_blank) skip_blank = 1'b1;
      end else begin
        if (opts.number_all || opts.number_nonblank) push_line_number();
        push_escaped(c);
        skip_blank = 1'b0;
        at_start   = 1'b0;
      end
    end else if (c == CH_LF) begin
      push_newline();
      at_start = 1'b1;
    end else begin
      push_escaped(c);
    end
    foreach (step_bytes[i])
      expected_bytes.push_back('{ch: step_bytes[i], last: 1'(i == step_bytes.size() - 1)});
  endfunction

  // ---------------------------------------------------------------- receiver and monitor

  always @(posedge clk) begin
    if (hold_taken != hold_req) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
      end else begin
        head_word = expected_bytes.pop_front();
        if (out_ch.out_byte !== head_word.ch)
          report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                    out_ch.out_byte, head_word.ch));
        if (out_ch.last !== head_word.last)
          report_mismatch($sformatf("last %b, predicted %b (byte %02h)",
                                    out_ch.last, head_word.last, head_word.ch));
      end
    end
  end

  // ---------------------------------------------------------------- sender side

  task automatic send_word(input logic [7:0] c, input logic nf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= c;
    in_ch.new_file  <= nf;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(c, nf);
  endtask

  // writes all six options, then the unused indexes, which must change nothing
  task automatic set_options(input cfg_t o);
    cfg_idx_t idx[6];
    logic     val[6];
    idx = '{CFG_NUMBER_ALL, CFG_NUMBER_NONBLANK, CFG_SQUEEZE_BLANK,
            CFG_DOLLAR_EOL, CFG_CARET_TAB, CFG_SHOW_NONPRINTING};
    val = '{o.number_all, o.number_nonblank, o.squeeze_blank,
            o.dollar_eol, o.caret_tab, o.show_nonprinting};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_index <= CFG_SPARE_LO;
    cfg_data  <= 1'($urandom_range(1));
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_data  <= 1'($urandom_range(1));
    @(posedge clk);
    cfg_we <= 1'b0;
    opts = o;
  endtask

  // squeezed words give no output, so allow the pipeline to settle as well
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 24)      return CH_LF;
    else if (r < 32) return CH_TAB;
    else if (r < 70) return 8'($urandom_range(32, 126));
    else if (r < 78) return 8'($urandom_range(0, 31));
    else if (r < 81) return CH_DEL;
    else             return 8'($urandom_range(128, 255));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_escapes();
    cfg_t       o;
    logic [7:0] probe[17];
    o = '0;
    o.number_all       = 1'b1;
    o.number_nonblank  = 1'b1;
    o.squeeze_blank    = 1'b1;
    o.dollar_eol       = 1'b1;
    o.show_nonprinting = 1'b1;
    set_options(o);
    probe = '{8'h41, 8'h00, CH_TAB, 8'h1F, CH_DEL, 8'h80, 8'h89, 8'h9F, CH_HI_SP,
              8'hFE, CH_HI_DEL, CH_LF, CH_LF, CH_LF, 8'h7E, CH_SPACE, CH_LF};
    foreach (probe[k]) send_word(probe[k], k == 0);
    wait_for_idle();
  endtask

  task automatic test_squeeze_release();
    cfg_t o;
    o = '0;
    o.number_all    = 1'b1;
    o.squeeze_blank = 1'b1;
    o.caret_tab     = 1'b1;
    set_options(o);
    send_word(CH_LF, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_LF, 1'b1);
    send_word(CH_LF, 1'b0);
    wait_for_idle();
    // with squeezing cleared the next blank line prints again
    o.squeeze_blank = 1'b0;
    set_options(o);
    send_word(CH_LF, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b1);
    send_word(CH_LF, 1'b0);
    wait_for_idle();
  endtask

  task automatic test_back_pressure();
    cfg_t o;
    int   saved_idle;
    o = '0;
    o.number_all       = 1'b1;
    o.show_nonprinting = 1'b1;
    set_options(o);
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    // receiver holds off while words keep coming, so the queue fills
    hold_req <= hold_req + 1;
    for (int k = 0; k < 16; k++) send_word((k % 4 == 3) ? CH_LF : CH_HI_DEL, 1'b0);
    wait_for_idle();
    for (int k = 0; k < 12; k++) send_word(pick_text_byte(), 1'b0);
    wait_for_idle();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_random_text(input int n_words, input cfg_t o);
    int         sent;
    int         run;
    logic [7:0] c;
    set_options(o);
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(7) == 0) begin
        // run of blank lines
        run = $urandom_range(2, 4);
        for (int k = 0; k < run; k++) send_word(CH_LF, 1'b0);
        sent += run;
      end else begin
        c = pick_text_byte();
        send_word(c, $urandom_range(24) == 0);
        sent++;
      end
    end
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.new_file  = 1'b0;
    out_ch.ready    = 1'b0;
    n_errors        = 0;
    hold_req        = 0;
    hold_taken      = 0;
    hold_left       = 0;
    opts            = '0;
    at_start        = 1'b1;
    skip_blank      = 1'b0;
    line_bcd        = 1;
    send_idle_pct   = 19;
    recv_stall_pct  = 75;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_escapes();
    test_squeeze_release();
    test_random_text(56, '0);
    test_random_text(56, '1);

    send_idle_pct  = 75;
    recv_stall_pct = 19;
    test_back_pressure();
    test_random_text(56, cfg_t'($urandom_range(63)));
    test_random_text(56, cfg_t'($urandom_range(63)));

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_text(56, cfg_t'($urandom_range(63)));
    test_random_text(56, cfg_t'($urandom_range(63)));
    test_random_text(40, cfg_t'(6'b100000));

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
